// ===== design/buffer_underflow_hysteresis_monitor_macros.svh =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor assertion macros
// Shared concurrent assertion forms for the monitor's checker.
// ----------------------------------------------------------------------------
`ifndef BUFFER_UNDERFLOW_HYSTERESIS_MONITOR_MACROS_SVH
`define BUFFER_UNDERFLOW_HYSTERESIS_MONITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BUFMON_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bufmon assertion failed: implication");

// The condition must never be seen outside reset.
`define BUFMON_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bufmon assertion failed: forbidden condition");

`endif

// ===== design/bufmon_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor package
// Widths, codes, word types and the divide-by-three helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bufmon_pkg;

    localparam int DEPTH_BITS = 28;
    localparam int TICK_BITS  = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int AV_W       = DEPTH_BITS + 1;
    localparam int RTHR_W     = CFG_W - 5;
    localparam int CMP_W      = (AV_W > RTHR_W) ? AV_W : RTHR_W;

    localparam logic [CFG_W-1:0] DEFAULT_BITRATE = 32'd2500000;
    localparam logic [CFG_W-1:0] DEFAULT_TIMEOUT = 32'd3000;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BITRATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_ENABLE   = 2'd2;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    localparam logic EV_RESUME = 1'b0;
    localparam logic EV_PAUSE  = 1'b1;

    typedef enum logic [1:0] {
        ST_PREPARING = 2'd0,
        ST_BUFFERING = 2'd1,
        ST_COMPLETED = 2'd2
    } state_t;

    // Exact x/3 for x below 2**DEPTH_BITS: multiply by ceil(2**(D+2)/3), shift.
    localparam int DIV3_SHIFT = DEPTH_BITS + 2;
    localparam int PROD_W     = 2 * DEPTH_BITS + 2;
    localparam logic [63:0] DIV3_MULT_FULL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
    localparam logic [DEPTH_BITS:0] DIV3_MULT = DIV3_MULT_FULL[DEPTH_BITS:0];

    typedef struct packed {
        logic                  command;
        logic [1:0]            new_state;
        logic [TICK_BITS-1:0]  now_tick;
        logic [DEPTH_BITS-1:0] video_depth;
        logic [DEPTH_BITS-1:0] audio_depth;
        logic [DEPTH_BITS-1:0] pump_depth;
        logic [DEPTH_BITS-1:0] pump_fifo_size;
    } item_t;

    typedef struct packed {
        logic       event_valid;
        logic       event_state;
        logic [1:0] buffer_state;
        logic       underflow;
    } result_t;

    typedef struct packed {
        logic [RTHR_W-1:0] resume_thr;
        logic [CFG_W-1:0]  timeout_ticks;
        logic              sink_enabled;
    } cfg_t;

    // One registered word with its thresholds already derived from the FIFO size.
    typedef struct packed {
        logic                  command;
        logic [1:0]            new_state;
        logic [TICK_BITS-1:0]  now_tick;
        logic [AV_W-1:0]       av_depth;
        logic [DEPTH_BITS-1:0] pump_depth;
        logic [DEPTH_BITS-1:0] under_prep;
        logic [DEPTH_BITS-1:0] enough_prep;
        logic [DEPTH_BITS-1:0] under_buf;
        logic [DEPTH_BITS-1:0] enough_buf;
    } stage_t;

    function automatic logic [DEPTH_BITS-1:0] div3(input logic [DEPTH_BITS-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(DIV3_MULT);
        return prod[DIV3_SHIFT +: DEPTH_BITS];
    endfunction

endpackage

// ===== design/bufmon_if.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bufmon_item_if;
    logic               valid;
    logic               ready;
    bufmon_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bufmon_result_if;
    logic                 valid;
    logic                 ready;
    bufmon_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/buffer_underflow_hysteresis_monitor.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow hysteresis monitor
// Playback buffer state tracker with timeout resume and hysteresis pause.
// ----------------------------------------------------------------------------
// The monitor takes one word per clock while the output side is not
// stalled and returns exactly one result word for each, in order. A word
// is accepted into the input register together with the half,
// three-quarter, third and two-third thresholds split from its pump FIFO
// size in front of that register. The decision stage then updates the
// buffer state and loads the result register, which offers the result word
// until the output side takes it. The buffer state, the timeout start tick
// and the timing flag close their loop inside the decision stage, so a word
// may follow its predecessor without a gap. A result word that waits on the
// output side also holds the input register: a new word is taken whenever
// the input register is empty or is moving forward this cycle, and it moves
// forward only when the result register is empty or is being read in the
// same cycle.
// Configuration writes take effect on the next clock and are meant to be
// issued only while no word is in flight.
`timescale 1ns / 1ps

module buffer_underflow_hysteresis_monitor
(
    input  logic                              clk,
    input  logic                              rst_n,
    bufmon_item_if.sink                       item,
    bufmon_result_if.source                   result,
    input  logic                              cfg_we,
    input  logic [bufmon_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bufmon_pkg::CFG_W-1:0]      cfg_data
);

    // Current register settings: resume threshold (bitrate >> 5, with a
    // zero bitrate mapped to the default), timeout and event enable.
    bufmon_pkg::cfg_t   cfg;

    // Word held in the input register, ready for the decision stage.
    logic               stage_valid;
    bufmon_pkg::stage_t stage;

    // High when the decision stage can take the held word this cycle.
    logic               advance;

    bufmon_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register with the FIFO fraction arithmetic in front of it.
    bufmon_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // Timeout resume, hysteresis check, state update and result register.
    bufmon_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .advance     (advance),
        .result      (result)
    );

endmodule

// ===== design/bufmon_cfg.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor configuration registers
// Holds timeout, resume threshold and event enable written by the host.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bufmon_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bufmon_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bufmon_pkg::CFG_W-1:0]       cfg_data,
    output bufmon_pkg::cfg_t                   cfg
);

    bufmon_pkg::cfg_t             cfg_reg;
    bufmon_pkg::cfg_t             cfg_next;
    logic [bufmon_pkg::CFG_W-1:0] rate;

    // A zero bitrate falls back to the default; the shift is stored, not the rate.
    always_comb
    begin
        rate     = (cfg_data == '0) ? bufmon_pkg::DEFAULT_BITRATE : cfg_data;
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bufmon_pkg::CFG_MAX_BITRATE:
                    cfg_next.resume_thr = bufmon_pkg::RTHR_W'(rate >> 5);
                bufmon_pkg::CFG_TIMEOUT_TICKS:
                    cfg_next.timeout_ticks = cfg_data;
                bufmon_pkg::CFG_SINK_ENABLE:
                    cfg_next.sink_enabled = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resume_thr    <= bufmon_pkg::RTHR_W'(bufmon_pkg::DEFAULT_BITRATE >> 5);
            cfg_reg.timeout_ticks <= bufmon_pkg::DEFAULT_TIMEOUT;
            cfg_reg.sink_enabled  <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bufmon_front.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor input register
// Accepts a word, derives the FIFO fraction thresholds and holds it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bufmon_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    bufmon_item_if.sink          item,
    input  logic                 advance,
    output logic                 stage_valid,
    output bufmon_pkg::stage_t   stage
);

    logic                              valid_reg;
    logic                              valid_next;
    bufmon_pkg::stage_t                stage_reg;
    bufmon_pkg::stage_t                stage_next;
    logic                              accept;
    logic [bufmon_pkg::DEPTH_BITS-1:0] fsize;
    logic [bufmon_pkg::DEPTH_BITS-3:0] quarter;
    logic [bufmon_pkg::DEPTH_BITS-1:0] third;

    assign item.ready = !valid_reg || advance;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        fsize   = item.data.pump_fifo_size;
        quarter = fsize[bufmon_pkg::DEPTH_BITS-1:2];
        third   = bufmon_pkg::div3(fsize);

        stage_next.command     = item.data.command;
        stage_next.new_state   = item.data.new_state;
        stage_next.now_tick    = item.data.now_tick;
        stage_next.av_depth    = bufmon_pkg::AV_W'(item.data.video_depth)
                               + bufmon_pkg::AV_W'(item.data.audio_depth);
        stage_next.pump_depth  = item.data.pump_depth;
        stage_next.under_prep  = fsize >> 1;
        stage_next.enough_prep = bufmon_pkg::DEPTH_BITS'({1'b0, quarter, 1'b0})
                               + bufmon_pkg::DEPTH_BITS'(quarter);
        stage_next.under_buf   = third;
        stage_next.enough_buf  = third << 1;

        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== design/bufmon_core.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor decision stage
// Timeout and hysteresis decision, buffer state and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bufmon_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bufmon_pkg::cfg_t     cfg,
    input  logic                 stage_valid,
    input  bufmon_pkg::stage_t   stage,
    output logic                 advance,
    bufmon_result_if.source      result
);

    bufmon_pkg::state_t               st_reg;
    bufmon_pkg::state_t               st_next;
    logic                             timing_reg;
    logic                             timing_next;
    logic [bufmon_pkg::TICK_BITS-1:0] start_reg;
    logic [bufmon_pkg::TICK_BITS-1:0] start_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    bufmon_pkg::result_t              out_reg;
    bufmon_pkg::result_t              out_next;

    logic                              fire;
    logic                              waiting;
    logic                              set_ok;
    logic [bufmon_pkg::TICK_BITS-1:0]  elapsed;
    logic                              timed_out;
    logic                              av_ok;
    logic [bufmon_pkg::DEPTH_BITS-1:0] under;
    logic [bufmon_pkg::DEPTH_BITS-1:0] enough;
    logic                              chk;
    logic                              run_check;

    assign advance = !out_valid_reg || result.ready;
    assign fire    = stage_valid && advance;

    always_comb
    begin
        waiting   = (st_reg == bufmon_pkg::ST_PREPARING) || (st_reg == bufmon_pkg::ST_BUFFERING);
        set_ok    = (stage.new_state == bufmon_pkg::ST_PREPARING)
                 || (stage.new_state == bufmon_pkg::ST_BUFFERING)
                 || (stage.new_state == bufmon_pkg::ST_COMPLETED);
        elapsed   = stage.now_tick - start_reg;
        timed_out = bufmon_pkg::CFG_W'(elapsed) >= cfg.timeout_ticks;
        av_ok     = bufmon_pkg::CMP_W'(stage.av_depth) >= bufmon_pkg::CMP_W'(cfg.resume_thr);

        if (st_reg == bufmon_pkg::ST_PREPARING)
        begin
            under  = stage.under_prep;
            enough = stage.enough_prep;
        end
        else
        begin
            under  = stage.under_buf;
            enough = stage.enough_buf;
        end

        if (stage.av_depth > bufmon_pkg::AV_W'(enough))
            chk = 1'b0;
        else if (stage.av_depth < bufmon_pkg::AV_W'(under))
            chk = !(stage.pump_depth > under);
        else
            chk = waiting;

        st_next                = st_reg;
        timing_next            = timing_reg;
        start_next             = start_reg;
        run_check              = 1'b0;
        out_next.event_valid   = 1'b0;
        out_next.event_state   = bufmon_pkg::EV_RESUME;
        out_next.underflow     = 1'b0;

        if (stage.command == bufmon_pkg::CMD_SET)
        begin
            if (set_ok)
            begin
                st_next = bufmon_pkg::state_t'(stage.new_state);
                if ((stage.new_state == bufmon_pkg::ST_COMPLETED) && cfg.sink_enabled)
                    out_next.event_valid = 1'b1;
            end
        end
        else
        begin
            run_check = 1'b1;
            if (!timing_reg)
            begin
                start_next  = stage.now_tick;
                timing_next = 1'b1;
            end
            else if (!waiting)
            begin
                timing_next = 1'b0;
            end
            else if (timed_out)
            begin
                run_check = 1'b0;
                if (av_ok)
                begin
                    timing_next = 1'b0;
                    if (cfg.sink_enabled)
                    begin
                        st_next              = bufmon_pkg::ST_COMPLETED;
                        out_next.event_valid = 1'b1;
                    end
                end
            end
        end

        if (run_check)
        begin
            out_next.underflow = chk;
            if (cfg.sink_enabled)
            begin
                if (!chk && waiting)
                begin
                    st_next              = bufmon_pkg::ST_COMPLETED;
                    out_next.event_valid = 1'b1;
                end
                else if (chk && (st_reg == bufmon_pkg::ST_COMPLETED))
                begin
                    st_next              = bufmon_pkg::ST_BUFFERING;
                    out_next.event_valid = 1'b1;
                    out_next.event_state = bufmon_pkg::EV_PAUSE;
                end
            end
        end

        out_next.buffer_state = st_next;

        if (fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= bufmon_pkg::ST_PREPARING;
            timing_reg    <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                st_reg     <= st_next;
                timing_reg <= timing_next;
                start_reg  <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

// ===== design/bufmon_checker.sv =====
// ----------------------------------------------------------------------------
// Buffer underflow monitor checker
// Consistency checks on result words seen at the monitor's ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "buffer_underflow_hysteresis_monitor_macros.svh"

module bufmon_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  bufmon_pkg::result_t  res_data
);

    // A pause is only ever reported together with an event.
    `BUFMON_ASSERT_IMPLY(a_pause_has_event, clk, rst_n, res_valid && (res_data.event_state == bufmon_pkg::EV_PAUSE), res_data.event_valid)

    // A pause event leaves the monitor buffering.
    `BUFMON_ASSERT_IMPLY(a_pause_state, clk, rst_n, res_valid && res_data.event_valid && (res_data.event_state == bufmon_pkg::EV_PAUSE), res_data.buffer_state == bufmon_pkg::ST_BUFFERING)

    // A resume event leaves the monitor completed and never reports underflow.
    `BUFMON_ASSERT_IMPLY(a_resume_state, clk, rst_n, res_valid && res_data.event_valid && (res_data.event_state == bufmon_pkg::EV_RESUME), (res_data.buffer_state == bufmon_pkg::ST_COMPLETED) && !res_data.underflow)

    // The reported state is always one of the three defined states.
    `BUFMON_ASSERT_NEVER(a_state_code, clk, rst_n, res_valid && (res_data.buffer_state != bufmon_pkg::ST_PREPARING) && (res_data.buffer_state != bufmon_pkg::ST_BUFFERING) && (res_data.buffer_state != bufmon_pkg::ST_COMPLETED))

endmodule

bind buffer_underflow_hysteresis_monitor bufmon_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_data  (result.data)
);
